[rtl/chip8_superchip_execute_unit_assert.svh]
// assertion macros for the execute unit checker
`ifndef CHIP8_SUPERCHIP_EXECUTE_UNIT_ASSERT_SVH
`define CHIP8_SUPERCHIP_EXECUTE_UNIT_ASSERT_SVH
// implication checked every clock outside reset
`define C8_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication checked every clock outside reset
`define C8_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

[rtl/c8x_pkg.sv]
// ----------------------------------------------------------------------------
// c8x_pkg
// shared types and constants of the super-chip execute unit
// ----------------------------------------------------------------------------
package c8x_pkg;
   localparam int MEMORY_BYTES = 4096;
   localparam int STACK_DEPTH  = 16;
   localparam int ADDR_W       = 12;
   localparam logic [11:0] START_PC = 12'h200;

   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_EXEC  = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;
   localparam logic [1:0] KIND_KEY   = 2'd3;

   localparam logic [2:0] EV_NONE    = 3'd0;
   localparam logic [2:0] EV_DISPLAY = 3'd1;
   localparam logic [2:0] EV_SOUNDIRQ= 3'd2;
   localparam logic [2:0] EV_KEYWAIT = 3'd3;
   localparam logic [2:0] EV_ILLEGAL = 3'd4;
   localparam logic [2:0] EV_SOUND   = 3'd5;
   localparam logic [2:0] EV_FLAGS   = 3'd6;

   // memory port request from the sequencer
   typedef struct packed {
      logic        wr;
      logic [11:0] addr;
      logic [7:0]  wdata;
   } mem_req_type;
endpackage

[rtl/c8x_ram.sv]
// ----------------------------------------------------------------------------
// c8x_ram
// 4096 by 8 program memory, one port, registered read data
// ----------------------------------------------------------------------------
module c8x_ram (
   input  logic                 clock,
   input  c8x_pkg::mem_req_type req,
   output logic [7:0]           rdata
);
   logic [7:0] mem [c8x_pkg::MEMORY_BYTES];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (req.wr) begin
         mem[req.addr] <= req.wdata;
      end
      rdata_ff <= mem[req.addr];
   end
   assign rdata = rdata_ff;
endmodule

[rtl/chip8_superchip_execute_unit.sv]
// ----------------------------------------------------------------------------
// chip8_superchip_execute_unit
// super-chip cpu core: memory, registers, stack, timer; one result per item
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// req      in         req_valid/req_ready  kind, load address/data, keys, random
// rsp      out        rsp_valid/rsp_ready  pc, event, frame sync, opcode, value
// csr      in         csr_valid/csr_ready  index advance bit
// load, tick, key items: result valid in the cycle after accept.
// execute: two fetches, decode, execute, then block store (up to 16 bytes)
// and bcd (3 bytes) write one byte per step, block load (up to 16 bytes)
// reads address then data per byte, flags one register per step (up to 8).
// the sequencer walks the single memory port byte by byte.
// reset is synchronous; the memory and the return stack are not cleared.
// a waiting result holds the block; the next item is taken once it leaves.
module chip8_superchip_execute_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [11:0] req_load_address,
   input  logic [7:0]  req_load_data,
   input  logic [15:0] req_keys_held,
   input  logic [7:0]  req_random_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_program_counter,
   output logic [2:0]  rsp_event_res,
   output logic        rsp_frame_sync,
   output logic [15:0] rsp_event_opcode,
   output logic [7:0]  rsp_event_value,
   output logic        rsp_high_resolution,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index_advance_on_block
);
   typedef enum logic [3:0] {
      S_IDLE, S_FETCH_HI, S_FETCH_LO, S_WAIT_LO, S_EXEC, S_BCD, S_STORE,
      S_LOAD_ADDR, S_LOAD_DATA, S_FLAGS, S_RESP
   } state_type;

   state_type   state_ff;
   logic [7:0]  v_ff [16];
   logic [7:0]  flag_ff [8];
   logic [11:0] stack_ff [c8x_pkg::STACK_DEPTH];
   logic [11:0] i_ff, pc_ff;
   logic [3:0]  sp_ff, key_target_ff, cnt_ff;
   logic [7:0]  dt_ff, hi_ff, lo_ff, rnd_ff;
   logic [15:0] keys_ff;
   logic        hires_ff, key_wait_ff, adv_ff;
   logic [2:0]  ev_ff;
   logic        fs_ff;
   logic [15:0] eop_ff;
   logic [7:0]  eval_ff;
   logic [1:0]  bcd_ff;
   logic [3:0]  hund_ff, tens_ff, ones_ff;

   c8x_pkg::mem_req_type mreq;
   logic [7:0] mrdata;

   c8x_ram u_ram (.clock(clock), .req(mreq), .rdata(mrdata));

   logic [3:0] x, y;
   logic [7:0] vx, vy;
   logic [15:0] op;
   logic [8:0] sum;
   logic [3:0] h100, t10;
   logic [7:0] r100;
   logic [15:0] t10_prod;
   logic held;

   assign x  = hi_ff[3:0];
   assign y  = lo_ff[7:4];
   assign vx = v_ff[x];
   assign vy = v_ff[y];
   assign op = {hi_ff, lo_ff};
   assign held = keys_ff[vx[3:0]] && (vx[7:4] == 4'd0);
   assign sum = {1'b0, vx} + {1'b0, (hi_ff[7:4] == 4'h8) ? vy : lo_ff};
   // bcd digits: compare chain for hundreds, reciprocal multiply for tens
   always_comb begin
      h100 = (vx >= 8'd200) ? 4'd2 : (vx >= 8'd100) ? 4'd1 : 4'd0;
      r100 = vx - 8'(h100) * 8'd100;
      t10_prod = {8'd0, r100} * 16'd205;
      t10 = t10_prod[14:11];
   end

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_program_counter = pc_ff;
   assign rsp_event_res = ev_ff;
   assign rsp_frame_sync = fs_ff;
   assign rsp_event_opcode = eop_ff;
   assign rsp_event_value = eval_ff;
   assign rsp_high_resolution = hires_ff;

   always_comb begin
      mreq = '0;
      case (state_ff)
         S_FETCH_HI: mreq.addr = pc_ff;
         S_FETCH_LO: mreq.addr = pc_ff + 12'd1;
         S_BCD: begin
            mreq.wr = 1'b1;
            mreq.addr = i_ff + {10'd0, bcd_ff};
            mreq.wdata = (bcd_ff == 2'd0) ? {4'd0, hund_ff} :
                         (bcd_ff == 2'd1) ? {4'd0, tens_ff} : {4'd0, ones_ff};
         end
         S_STORE: begin
            mreq.wr = 1'b1;
            mreq.addr = i_ff + {8'd0, cnt_ff};
            mreq.wdata = v_ff[cnt_ff];
         end
         S_LOAD_ADDR: mreq.addr = i_ff + {8'd0, cnt_ff};
         default: mreq = '0;
      endcase
      if (state_ff == S_IDLE && req_valid && req_kind == c8x_pkg::KIND_LOAD) begin
         mreq.wr = 1'b1;
         mreq.addr = req_load_address;
         mreq.wdata = req_load_data;
      end
   end

   task automatic illegal_op();
      ev_ff   <= c8x_pkg::EV_ILLEGAL;
      eop_ff  <= {hi_ff, lo_ff};
   endtask

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int k = 0; k < 16; k++) v_ff[k] <= '0;
         for (int k = 0; k < 8; k++) flag_ff[k] <= '0;
         i_ff <= '0; pc_ff <= c8x_pkg::START_PC; sp_ff <= '0; dt_ff <= '0;
         hires_ff <= 1'b0; key_wait_ff <= 1'b0; key_target_ff <= '0;
         adv_ff <= 1'b1;
      end else begin
         if (csr_valid && csr_ready) adv_ff <= csr_index_advance_on_block;
         case (state_ff)
            S_IDLE: if (req_valid) begin
               ev_ff <= c8x_pkg::EV_NONE; fs_ff <= 1'b0;
               eop_ff <= '0; eval_ff <= '0;
               keys_ff <= req_keys_held; rnd_ff <= req_random_byte;
               state_ff <= S_RESP;
               case (req_kind)
                  c8x_pkg::KIND_TICK: if (dt_ff != 8'd0) dt_ff <= dt_ff - 8'd1;
                  c8x_pkg::KIND_KEY: if (key_wait_ff) begin
                     v_ff[key_target_ff] <= req_load_data;
                     key_wait_ff <= 1'b0;
                  end
                  c8x_pkg::KIND_EXEC: begin
                     if (key_wait_ff) ev_ff <= c8x_pkg::EV_KEYWAIT;
                     else state_ff <= S_FETCH_HI;
                  end
                  default: ;
               endcase
            end
            S_FETCH_HI: state_ff <= S_FETCH_LO;
            S_FETCH_LO: begin hi_ff <= mrdata; state_ff <= S_WAIT_LO; end
            S_WAIT_LO: begin
               lo_ff <= mrdata; pc_ff <= pc_ff + 12'd2; state_ff <= S_EXEC;
            end
            S_EXEC: begin
               state_ff <= S_RESP;
               cnt_ff <= '0;
               case (hi_ff[7:4])
                  4'h0: begin
                     if (op >= 16'h00C1 && op <= 16'h00CF) begin
                        ev_ff <= c8x_pkg::EV_DISPLAY; eop_ff <= op;
                     end else if (op == 16'h00E0) begin
                        ev_ff <= c8x_pkg::EV_DISPLAY; fs_ff <= 1'b1; eop_ff <= op;
                     end else if (op == 16'h00EE) begin
                        sp_ff <= sp_ff - 4'd1; pc_ff <= stack_ff[sp_ff - 4'd1];
                     end else if (op == 16'h00FB || op == 16'h00FC) begin
                        ev_ff <= c8x_pkg::EV_DISPLAY; eop_ff <= op;
                     end else if (op == 16'h00FD) ev_ff <= c8x_pkg::EV_SOUNDIRQ;
                     else if (op == 16'h00FE || op == 16'h00FF) begin
                        hires_ff <= lo_ff[0];
                        ev_ff <= c8x_pkg::EV_DISPLAY; fs_ff <= 1'b1; eop_ff <= op;
                     end else illegal_op();
                  end
                  4'h1: pc_ff <= op[11:0];
                  4'h2: begin
                     stack_ff[sp_ff] <= pc_ff; sp_ff <= sp_ff + 4'd1;
                     pc_ff <= op[11:0];
                  end
                  4'h3: if (vx == lo_ff) pc_ff <= pc_ff + 12'd2;
                  4'h4: if (vx != lo_ff) pc_ff <= pc_ff + 12'd2;
                  4'h5, 4'h9: begin
                     if (lo_ff[3:0] != 4'd0) illegal_op();
                     else if ((vx == vy) != hi_ff[7]) pc_ff <= pc_ff + 12'd2;
                  end
                  4'h6: v_ff[x] <= lo_ff;
                  4'h7: v_ff[x] <= sum[7:0];
                  4'h8: begin
                     case (lo_ff[3:0])
                        4'h0: v_ff[x] <= vy;
                        4'h1: v_ff[x] <= vx | vy;
                        4'h2: v_ff[x] <= vx & vy;
                        4'h3: v_ff[x] <= vx ^ vy;
                        4'h4: begin v_ff[x] <= sum[7:0]; v_ff[15] <= {7'd0, sum[8]}; end
                        4'h5: begin
                           v_ff[x] <= vx - vy; v_ff[15] <= {7'd0, vx >= vy};
                        end
                        4'h7: begin
                           v_ff[x] <= vy - vx; v_ff[15] <= {7'd0, vy >= vx};
                        end
                        4'h6: begin v_ff[x] <= vx >> 1; v_ff[15] <= {7'd0, vx[0]}; end
                        4'hE: begin v_ff[x] <= vx << 1; v_ff[15] <= {7'd0, vx[7]}; end
                        default: illegal_op();
                     endcase
                  end
                  4'hA: i_ff <= op[11:0];
                  4'hB: pc_ff <= op[11:0] + {4'd0, vx};
                  4'hC: v_ff[x] <= rnd_ff & lo_ff;
                  4'hD: begin
                     ev_ff <= c8x_pkg::EV_DISPLAY; fs_ff <= ~hires_ff; eop_ff <= op;
                  end
                  4'hE: begin
                     if (lo_ff == 8'h9E) begin
                        if (held) pc_ff <= pc_ff + 12'd2;
                     end else if (lo_ff == 8'hA1) begin
                        if (!held) pc_ff <= pc_ff + 12'd2;
                     end else illegal_op();
                  end
                  default: begin
                     case (lo_ff)
                        8'h07: v_ff[x] <= dt_ff;
                        8'h0A: begin
                           key_wait_ff <= 1'b1; key_target_ff <= x;
                           ev_ff <= c8x_pkg::EV_KEYWAIT;
                        end
                        8'h15: dt_ff <= vx;
                        8'h18: begin
                           ev_ff <= c8x_pkg::EV_SOUND;
                           eval_ff <= (vx == 8'd1) ? 8'd2 : vx;
                        end
                        8'h1E: i_ff <= i_ff + {4'd0, vx};
                        8'h29: i_ff <= {6'd0, vx[3:0], 2'd0} + {8'd0, vx[3:0]};
                        8'h30: i_ff <= {5'd0, vx[3:0], 3'd0} + {7'd0, vx[3:0], 1'b0}
                                      + 12'd80;
                        8'h33: begin
                           hund_ff <= h100; tens_ff <= t10;
                           ones_ff <= 4'(r100 - 8'(t10) * 8'd10);
                           bcd_ff <= '0; state_ff <= S_BCD;
                        end
                        8'h55: state_ff <= S_STORE;
                        8'h65: state_ff <= S_LOAD_ADDR;
                        8'h75, 8'h85: begin
                           ev_ff <= c8x_pkg::EV_FLAGS;
                           eval_ff <= x[3] ? 8'd8 : {4'd0, x} + 8'd1;
                           state_ff <= S_FLAGS;
                        end
                        default: illegal_op();
                     endcase
                  end
               endcase
            end
            S_BCD: begin
               bcd_ff <= bcd_ff + 2'd1;
               if (bcd_ff == 2'd2) state_ff <= S_RESP;
            end
            S_STORE: begin
               cnt_ff <= cnt_ff + 4'd1;
               if (cnt_ff == x) begin
                  if (adv_ff) i_ff <= i_ff + {8'd0, x};
                  state_ff <= S_RESP;
               end
            end
            S_LOAD_ADDR: state_ff <= S_LOAD_DATA;
            S_LOAD_DATA: begin
               v_ff[cnt_ff] <= mrdata;
               cnt_ff <= cnt_ff + 4'd1;
               if (cnt_ff == x) begin
                  if (adv_ff) i_ff <= i_ff + {8'd0, x};
                  state_ff <= S_RESP;
               end else state_ff <= S_LOAD_ADDR;
            end
            S_FLAGS: begin
               // one register per cycle, up to eight
               if (lo_ff[7:4] == 4'h7) flag_ff[cnt_ff[2:0]] <= v_ff[cnt_ff];
               else v_ff[cnt_ff] <= flag_ff[cnt_ff[2:0]];
               cnt_ff <= cnt_ff + 4'd1;
               if (cnt_ff == 4'(eval_ff - 8'd1)) state_ff <= S_RESP;
            end
            S_RESP: if (rsp_ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

[rtl/c8x_checker.sv]
// ----------------------------------------------------------------------------
// c8x_checker
// port-level checks of the execute unit
// ----------------------------------------------------------------------------
`include "chip8_superchip_execute_unit_assert.svh"
module c8x_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_event_res,
   input logic       rsp_frame_sync
);
   // one item in flight: no new item while a result waits
   `C8_ASSERT_IMP(a_no_accept_busy, clock, reset, rsp_valid, !req_ready, "accepted while busy")
   `C8_ASSERT_NEXT(a_rsp_after, clock, reset, rsp_valid && rsp_ready, req_ready,
      "not idle after result")
   `C8_ASSERT_IMP(a_ev_range, clock, reset, rsp_valid,
      rsp_event_res <= c8x_pkg::EV_FLAGS, "bad event code")
   `C8_ASSERT_IMP(a_fs_display, clock, reset, rsp_valid && rsp_frame_sync,
      rsp_event_res == c8x_pkg::EV_DISPLAY, "frame sync without display")
endmodule

bind chip8_superchip_execute_unit c8x_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_event_res(rsp_event_res),
   .rsp_frame_sync(rsp_frame_sync)
);
